// ----- rtl/bytea_escape_decoder_assert.svh -----
// Assertion macros for the escape decoder.
`ifndef BYTEA_ESCAPE_DECODER_ASSERT_SVH
`define BYTEA_ESCAPE_DECODER_ASSERT_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define BED_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// cond must never be true outside reset
`define BED_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BED_ASSERT(label, clk, rst, prop, msg)
`define BED_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ----- rtl/bed_pkg.sv -----
package bed_pkg;

  localparam logic [7:0] BS_CHAR    = 8'h5C;
  localparam logic [7:0] OCT_LO     = 8'h30;
  localparam logic [7:0] OCT_HI     = 8'h37;
  localparam logic [1:0] MAX_DIGITS = 2'd3;

  // One decoded item: one or two bytes, each with its end flag.
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic       e0;
    logic [7:0] b1;
    logic       e1;
  } dec_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/bed_front.sv -----
`include "bytea_escape_decoder_assert.svh"

module bed_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          text_byte,
  input  logic                text_end,
  input  bed_pkg::q_stat_t    q_stat,
  output logic                in_full,
  output logic                q_push,
  output bed_pkg::dec_entry_t q_wdata
);
  import bed_pkg::*;

  logic       esc_open, esc_open_next;
  logic [1:0] digits, digits_next;
  logic [7:0] accum, accum_next;

  logic       accept;
  logic       is_oct;
  logic [2:0] dval;
  logic [7:0] acc_t;
  logic [1:0] dig_t;
  logic       emit0, emit1;
  logic       plain_open;

  assign in_full = q_stat.full;
  assign accept  = in_valid && !q_stat.full;
  assign is_oct  = (text_byte >= OCT_LO) && (text_byte <= OCT_HI);
  assign dval    = text_byte[2:0];
  assign acc_t   = {accum[4:0], dval};
  assign dig_t   = digits + 2'd1;
  // a backslash that is not last opens an escape instead of being emitted
  assign plain_open = (text_byte == BS_CHAR) && !text_end;

  always_comb begin
    esc_open_next = esc_open;
    digits_next   = digits;
    accum_next    = accum;
    emit0         = 1'b0;
    emit1         = 1'b0;
    q_wdata       = '0;
    if (!esc_open) begin
      if (plain_open) begin
        esc_open_next = 1'b1;
        digits_next   = 2'd0;
        accum_next    = 8'd0;
      end else begin
        emit0      = 1'b1;
        q_wdata.b0 = text_byte;
        q_wdata.e0 = text_end;
      end
    end else if (digits == 2'd0) begin
      if (text_byte == BS_CHAR) begin
        esc_open_next = 1'b0;
        emit0         = 1'b1;
        q_wdata.b0    = BS_CHAR;
        q_wdata.e0    = text_end;
      end else if (is_oct) begin
        accum_next  = {5'd0, dval};
        digits_next = 2'd1;
        if (text_end) begin
          emit0      = 1'b1;
          q_wdata.b0 = {5'd0, dval};
          q_wdata.e0 = 1'b1;
        end
      end else begin
        esc_open_next = 1'b0;
        digits_next   = 2'd0;
        accum_next    = 8'd0;
        emit0         = 1'b1;
        q_wdata.b0    = BS_CHAR;
        q_wdata.e0    = 1'b0;
        if (plain_open) begin
          esc_open_next = 1'b1;
        end else begin
          emit1      = 1'b1;
          q_wdata.b1 = text_byte;
          q_wdata.e1 = text_end;
        end
      end
    end else begin
      if (is_oct) begin
        accum_next  = acc_t;
        digits_next = dig_t;
        if (dig_t == MAX_DIGITS || text_end) begin
          esc_open_next = 1'b0;
          digits_next   = 2'd0;
          accum_next    = 8'd0;
          emit0         = 1'b1;
          q_wdata.b0    = acc_t;
          q_wdata.e0    = text_end;
        end
      end else begin
        esc_open_next = 1'b0;
        digits_next   = 2'd0;
        accum_next    = 8'd0;
        emit0         = 1'b1;
        q_wdata.b0    = accum;
        q_wdata.e0    = 1'b0;
        if (plain_open) begin
          esc_open_next = 1'b1;
        end else begin
          emit1      = 1'b1;
          q_wdata.b1 = text_byte;
          q_wdata.e1 = text_end;
        end
      end
    end
    // end of string always leaves a clean state
    if (text_end) begin
      esc_open_next = 1'b0;
      digits_next   = 2'd0;
      accum_next    = 8'd0;
    end
    q_wdata.two = emit1;
  end

  assign q_push = accept && emit0;

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_open <= 1'b0;
      digits   <= 2'd0;
      accum    <= 8'd0;
    end else if (accept) begin
      esc_open <= esc_open_next;
      digits   <= digits_next;
      accum    <= accum_next;
    end
  end

  `BED_ASSERT(a_closed_clean, clk, rst, !esc_open |-> (digits == 2'd0 && accum == 8'd0), "closed escape holds digits")
  `BED_NEVER(a_digits_range, clk, rst, digits == MAX_DIGITS, "three digits left pending")
  `BED_ASSERT(a_end_emits, clk, rst, (accept && text_end) |-> q_push, "last item gave no byte")

endmodule

// ----- rtl/bed_queue.sv -----
`include "bytea_escape_decoder_assert.svh"

module bed_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bed_pkg::dec_entry_t wdata,
  input  logic                pop,
  output bed_pkg::dec_entry_t rdata,
  output bed_pkg::q_stat_t    stat
);
  import bed_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dec_entry_t      mem [DEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `BED_NEVER(a_q_overflow, clk, rst, count > CW'(DEPTH), "queue count past depth")

endmodule

// ----- rtl/bed_back.sv -----
`include "bytea_escape_decoder_assert.svh"

module bed_back (
  input  logic                clk,
  input  logic                rst,
  input  bed_pkg::q_stat_t    q_stat,
  input  bed_pkg::dec_entry_t q_rdata,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output logic [7:0]          data_byte,
  output logic                data_end
);
  import bed_pkg::*;

  logic       out_valid;
  logic       pend;
  logic [7:0] pend_byte;
  logic       pend_end;
  logic       load_ok;

  assign out_empty = !out_valid;
  assign load_ok   = !out_valid || out_pop;
  // second byte of an item goes out before the next item is taken
  assign q_pop     = load_ok && !pend && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load_ok) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else begin
        out_valid <= !q_stat.empty;
        pend      <= !q_stat.empty && q_rdata.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (pend) begin
        data_byte <= pend_byte;
        data_end  <= pend_end;
      end else if (!q_stat.empty) begin
        data_byte <= q_rdata.b0;
        data_end  <= q_rdata.e0;
        pend_byte <= q_rdata.b1;
        pend_end  <= q_rdata.e1;
      end
    end
  end

  `BED_ASSERT(a_pend_has_out, clk, rst, pend |-> out_valid, "second byte waits with no first")
  `BED_NEVER(a_pop_while_pend, clk, rst, q_pop && pend, "queue read with byte pending")

endmodule

// ----- rtl/bytea_escape_decoder.sv -----
// Escape-format bytea decoder. Text bytes go in through push/full, one per cycle;
// decoded bytes come out through empty/pop, one per cycle, with data_end on the
// last byte of each string. A text byte is taken in the cycle it is pushed unless
// the internal queue of QDEPTH decoded items is full; the front decodes it at
// once. A decoded byte passes through the queue and the output register. The result
// side moves one byte per cycle while it is popped, so an item that decodes to two bytes (an escape
// ended by a plain character) holds the output for both of its bytes, and a run of
// such items lets the front take text bytes only as fast as the output drains the
// queue once it has filled. Items that decode to no byte (an opening backslash,
// inner octal digits) use no output slot.
module bytea_escape_decoder #(
  parameter int QDEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  input  logic       text_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte,
  output logic       data_end
);
  import bed_pkg::*;

  q_stat_t    q_stat;
  logic       q_push, q_pop;
  dec_entry_t q_wdata, q_rdata;

  bed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .text_byte (text_byte),
    .text_end  (text_end),
    .q_stat    (q_stat),
    .in_full   (full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  bed_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  bed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .data_byte (data_byte),
    .data_end  (data_end)
  );

endmodule
